// ===== src/lcal_pkg.sv =====
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared constants, command codes and the result word type of the
// lowest-common-ancestor lifting block.
// ----------------------------------------------------------------------------
package lcal_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int LEVELS_DEF    = 10;

    localparam int CMD_W   = 2;
    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

    localparam logic [CMD_W-1:0] CMD_ROOT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // result word from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] ancestor;
    } lcal_res_t;

endpackage

// ===== src/lcal_ram.sv =====
// ----------------------------------------------------------------------------
// lcal_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (held while no read is issued).
// ----------------------------------------------------------------------------
module lcal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lcal_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcal_ctrl
// Sequencer: walks the jump table and depth RAM for attach and query words,
// one dependent read at a time, and hands finished answers to the output.
// ----------------------------------------------------------------------------
module lcal_ctrl #(
    parameter int MAX_NODES = lcal_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = lcal_pkg::LEVELS_DEF,
    parameter int NW        = $clog2(MAX_NODES),
    parameter int JAW       = $clog2(MAX_NODES * LEVELS),
    parameter int DAW       = $clog2(MAX_NODES)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lcal_pkg::CMD_W-1:0]     s_command,
    input  logic [lcal_pkg::NODE_W-1:0]    s_node,
    input  logic [lcal_pkg::NODE_W-1:0]    s_other_node,
    output logic                           j_we,
    output logic [JAW-1:0]                 j_waddr,
    output logic [NW:0]                    j_wdata,
    output logic                           j_re,
    output logic [JAW-1:0]                 j_raddr,
    input  logic [NW:0]                    j_rdata,
    output logic                           d_we,
    output logic [DAW-1:0]                 d_waddr,
    output logic [lcal_pkg::DEPTH_W-1:0]   d_wdata,
    output logic                           d_re,
    output logic [DAW-1:0]                 d_raddr,
    input  logic [lcal_pkg::DEPTH_W-1:0]   d_rdata,
    output lcal_pkg::lcal_res_t            res,
    input  logic                           res_ready
);
    import lcal_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LW-1:0] LMAX = LW'(LEVELS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ROOT = 4'd1;
    localparam logic [3:0] ST_CDEP = 4'd2;
    localparam logic [3:0] ST_CRD  = 4'd3;
    localparam logic [3:0] ST_CWR  = 4'd4;
    localparam logic [3:0] ST_QD0  = 4'd5;
    localparam logic [3:0] ST_QD1  = 4'd6;
    localparam logic [3:0] ST_LA   = 4'd7;
    localparam logic [3:0] ST_LB   = 4'd8;
    localparam logic [3:0] ST_DA   = 4'd9;
    localparam logic [3:0] ST_DB   = 4'd10;
    localparam logic [3:0] ST_FIN  = 4'd11;
    localparam logic [3:0] ST_DONE = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [LW-1:0]      k_reg, k_next;
    logic [NW-1:0]      x_reg, x_next;
    logic [NW-1:0]      y_reg, y_next;
    logic [NW:0]        e_reg, e_next;       // entry: valid at MSB, index below
    logic [DEPTH_W-1:0] dcmp_reg, dcmp_next;
    logic [NODE_W-1:0]  ans_reg, ans_next;

    logic [NW-1:0] in_a, in_b, x_new, y_new;
    logic          a_ok, b_ok, take;
    logic [NW-1:0] jr_node;
    logic [LW-1:0] jr_lv;
    logic [NW-1:0] jw_node;
    logic [LW-1:0] jw_lv;

    function automatic logic [JAW-1:0] jaddr(input logic [NW-1:0] n, input logic [LW-1:0] lv);
        return JAW'(32'(n) * LEVELS + 32'(lv));
    endfunction

    assign in_a = NW'(s_node);
    assign in_b = NW'(s_other_node);
    assign a_ok = 32'(s_node) < 32'(MAX_NODES);
    assign b_ok = 32'(s_other_node) < 32'(MAX_NODES);

    assign s_ready      = (state_reg == ST_IDLE);
    assign res.valid    = (state_reg == ST_DONE);
    assign res.ancestor = ans_reg;

    assign j_raddr = jaddr(jr_node, jr_lv);
    assign j_waddr = jaddr(jw_node, jw_lv);

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        e_next     = e_reg;
        dcmp_next  = dcmp_reg;
        ans_next   = ans_reg;
        j_we       = 1'b0;
        jw_node    = x_reg;
        jw_lv      = k_reg;
        j_wdata    = '0;
        j_re       = 1'b0;
        jr_node    = x_reg;
        jr_lv      = k_reg;
        d_we       = 1'b0;
        d_waddr    = DAW'(x_reg);
        d_wdata    = '0;
        d_re       = 1'b0;
        d_raddr    = DAW'(y_reg);
        x_new      = x_reg;
        y_new      = y_reg;
        take       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next = in_a;
                    y_next = in_b;
                    case (s_command)
                        CMD_ROOT: begin
                            if (a_ok) begin
                                d_we       = 1'b1;
                                d_waddr    = DAW'(in_a);
                                k_next     = '0;
                                state_next = ST_ROOT;
                            end
                        end
                        CMD_CHILD: begin
                            if (a_ok && b_ok) begin
                                d_re       = 1'b1;
                                d_raddr    = DAW'(in_b);
                                state_next = ST_CDEP;
                            end
                        end
                        CMD_QUERY: begin
                            if (a_ok && b_ok) begin
                                d_re       = 1'b1;
                                d_raddr    = DAW'(in_a);
                                state_next = ST_QD0;
                            end else begin
                                ans_next   = '0;
                                state_next = ST_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROOT: begin
                j_we = 1'b1;
                if (k_reg == LMAX) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + LW'(1);
                end
            end
            ST_CDEP: begin
                d_we    = 1'b1;
                d_wdata = (d_rdata == DEPTH_MAX) ? DEPTH_MAX : d_rdata + DEPTH_W'(1);
                j_we    = 1'b1;
                jw_lv   = '0;
                j_wdata = {1'b1, y_reg};
                e_next  = {1'b1, y_reg};
                k_next  = LW'(1);
                state_next = (LEVELS == 1) ? ST_IDLE : ST_CRD;
            end
            ST_CRD: begin
                if (e_reg[NW]) begin
                    j_re       = 1'b1;
                    jr_node    = e_reg[NW-1:0];
                    jr_lv      = k_reg - LW'(1);
                    state_next = ST_CWR;
                end else begin
                    // chain ended: rest of the levels are empty
                    j_we = 1'b1;
                    if (k_reg == LMAX) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + LW'(1);
                    end
                end
            end
            ST_CWR: begin
                j_we    = 1'b1;
                j_wdata = j_rdata;
                e_next  = j_rdata;
                if (k_reg == LMAX) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + LW'(1);
                    state_next = ST_CRD;
                end
            end
            ST_QD0: begin
                dcmp_next  = d_rdata;
                d_re       = 1'b1;
                d_raddr    = DAW'(y_reg);
                state_next = ST_QD1;
            end
            ST_QD1: begin
                j_re  = 1'b1;
                jr_lv = LMAX;
                if (dcmp_reg < d_rdata) begin
                    x_next  = y_reg;
                    y_next  = x_reg;
                    jr_node = y_reg;
                end else begin
                    dcmp_next = d_rdata;
                    jr_node   = x_reg;
                end
                k_next     = LMAX;
                state_next = ST_LA;
            end
            ST_LA: begin
                e_next     = j_rdata;
                d_re       = 1'b1;
                d_raddr    = DAW'(j_rdata[NW-1:0]);
                state_next = ST_LB;
            end
            ST_LB: begin
                if (e_reg[NW] && (d_rdata >= dcmp_reg)) begin
                    x_new = e_reg[NW-1:0];
                end
                x_next  = x_new;
                j_re    = 1'b1;
                jr_node = x_new;
                if (k_reg == '0) begin
                    if (x_new == y_reg) begin
                        j_re       = 1'b0;
                        ans_next   = NODE_W'(x_new);
                        state_next = ST_DONE;
                    end else begin
                        jr_lv      = LMAX;
                        k_next     = LMAX;
                        state_next = ST_DA;
                    end
                end else begin
                    jr_lv      = k_reg - LW'(1);
                    k_next     = k_reg - LW'(1);
                    state_next = ST_LA;
                end
            end
            ST_DA: begin
                e_next     = j_rdata;
                j_re       = 1'b1;
                jr_node    = y_reg;
                state_next = ST_DB;
            end
            ST_DB: begin
                take = (e_reg != j_rdata) && e_reg[NW] && j_rdata[NW];
                if (take) begin
                    x_new = e_reg[NW-1:0];
                    y_new = j_rdata[NW-1:0];
                end
                x_next  = x_new;
                y_next  = y_new;
                j_re    = 1'b1;
                jr_node = x_new;
                if (k_reg == '0) begin
                    // last read fetches the parent of x
                    jr_lv      = '0;
                    state_next = ST_FIN;
                end else begin
                    jr_lv      = k_reg - LW'(1);
                    k_next     = k_reg - LW'(1);
                    state_next = ST_DA;
                end
            end
            ST_FIN: begin
                ans_next   = j_rdata[NW] ? NODE_W'(j_rdata[NW-1:0]) : '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        k_reg    <= k_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        e_reg    <= e_next;
        dcmp_reg <= dcmp_next;
        ans_reg  <= ans_next;
    end

endmodule

// ===== src/lcal_out.sv =====
// ----------------------------------------------------------------------------
// lcal_out
// Output register stage: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module lcal_out (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lcal_pkg::lcal_res_t         res,
    output logic                        res_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lcal_pkg::NODE_W-1:0] m_common_ancestor
);
    import lcal_pkg::*;

    logic              valid_reg;
    logic [NODE_W-1:0] data_reg;

    assign res_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res.valid;
        end
        if (res_ready && res.valid) begin
            data_reg <= res.ancestor;
        end
    end

    assign m_valid           = valid_reg;
    assign m_common_ancestor = data_reg;

endmodule

// ===== src/lowest_common_ancestor_lifting.sv =====
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting
// Rooted tree kept as a binary-lifting ancestor table; answers LCA queries.
// ----------------------------------------------------------------------------
// Each input word is a root attach, a child attach (parent attached first)
// or a query; only a query returns a word, its lowest common ancestor (0 for
// nodes in different trees or out of range). The tree lives in two RAMs:
// the jump table, MAX_NODES*LEVELS entries of valid bit plus ancestor index,
// and a depth per node. Neither is cleared after reset: a node must be
// attached before it is read. The sequencer makes one dependent read at a
// time on the jump table's single read port: a root attach writes every
// level empty, a child attach reads level k-1 of the ancestor and writes
// level k, and a query lifts the deeper node level by level, then climbs x
// and y together, sharing the port; it ends after the lift when the lift
// already meets the other node, and an out-of-range query reads no table. A new word
// is taken as soon as the sequencer is idle, even with a result still
// waiting in the output register.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting #(
    parameter int MAX_NODES = lcal_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = lcal_pkg::LEVELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lcal_pkg::CMD_W-1:0]  s_command,
    input  logic [lcal_pkg::NODE_W-1:0] s_node,
    input  logic [lcal_pkg::NODE_W-1:0] s_other_node,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lcal_pkg::NODE_W-1:0] m_common_ancestor
);
    import lcal_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);          // node index bits
    localparam int JAW = $clog2(MAX_NODES * LEVELS); // jump table address
    localparam int DAW = $clog2(MAX_NODES);          // depth RAM address

    // jump table port
    logic           j_we, j_re;
    logic [JAW-1:0] j_waddr, j_raddr;
    logic [NW:0]    j_wdata, j_rdata;

    // depth RAM port
    logic               d_we, d_re;
    logic [DAW-1:0]     d_waddr, d_raddr;
    logic [DEPTH_W-1:0] d_wdata, d_rdata;

    lcal_res_t res;
    logic      res_ready;

    lcal_ctrl #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS),
        .NW        (NW),
        .JAW       (JAW),
        .DAW       (DAW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_node       (s_node),
        .s_other_node (s_other_node),
        .j_we         (j_we),
        .j_waddr      (j_waddr),
        .j_wdata      (j_wdata),
        .j_re         (j_re),
        .j_raddr      (j_raddr),
        .j_rdata      (j_rdata),
        .d_we         (d_we),
        .d_waddr      (d_waddr),
        .d_wdata      (d_wdata),
        .d_re         (d_re),
        .d_raddr      (d_raddr),
        .d_rdata      (d_rdata),
        .res          (res),
        .res_ready    (res_ready)
    );

    // ancestor at distance 2**k of node n sits at n*LEVELS + k
    lcal_ram #(
        .WIDTH (NW + 1),
        .DEPTH (MAX_NODES * LEVELS),
        .AW    (JAW)
    ) u_jump_ram (
        .aclk  (aclk),
        .we    (j_we),
        .waddr (j_waddr),
        .wdata (j_wdata),
        .re    (j_re),
        .raddr (j_raddr),
        .rdata (j_rdata)
    );

    lcal_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_NODES),
        .AW    (DAW)
    ) u_depth_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    lcal_out u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .res               (res),
        .res_ready         (res_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_common_ancestor (m_common_ancestor)
    );

    // the sequencer keeps reads and writes of one entry apart
    a_jump_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(j_we && j_re && (j_waddr == j_raddr)))
        else $error("jump table read and write hit the same entry");

    a_depth_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(d_we && d_re && (d_waddr == d_raddr)))
        else $error("depth RAM read and write hit the same entry");

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res.valid)
        else $error("input taken while a result word is pending");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res_ready) |=> (res.valid && $stable(res.ancestor)))
        else $error("pending result word dropped or changed");

endmodule

// ===== test/lowest_common_ancestor_lifting_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_tb
// Self-checking bench for the binary-lifting LCA block: the bench keeps its
// own copy of the ancestor table and depths, predicts every query answer and
// compares the result words in order under random sender and receiver idling.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                        vld;
    logic [lcal_pkg::NODE_W-1:0] idx;
} hop_t;

class lca_tracker;
    localparam int NN = lcal_pkg::MAX_NODES_DEF;
    localparam int LL = lcal_pkg::LEVELS_DEF;

    hop_t                         hop [NN][LL];
    logic [lcal_pkg::DEPTH_W-1:0] depth [NN];
    logic [lcal_pkg::NODE_W-1:0]  ancestor_q [$];
    int errors;
    int checked;
    int attaches;
    int queries;

    function new();
        errors   = 0;
        checked  = 0;
        attaches = 0;
        queries  = 0;
    endfunction

    function int pending();
        return ancestor_q.size();
    endfunction

    task report(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        errors++;
    endtask

    function logic [lcal_pkg::NODE_W-1:0] lowest_common(
        logic [lcal_pkg::NODE_W-1:0] x, logic [lcal_pkg::NODE_W-1:0] y);
        logic [lcal_pkg::NODE_W-1:0] t;
        hop_t hx, hy;
        if (depth[x] < depth[y]) begin
            t = x;
            x = y;
            y = t;
        end
        // bring the deeper node up to the other's depth
        for (int k = LL - 1; k >= 0; k--) begin
            hx = hop[x][k];
            if (hx.vld && depth[hx.idx] >= depth[y]) begin
                x = hx.idx;
            end
        end
        if (x == y) begin
            return x;
        end
        // climb together while the ancestors still differ
        for (int k = LL - 1; k >= 0; k--) begin
            hx = hop[x][k];
            hy = hop[y][k];
            if (hx != hy && hx.vld && hy.vld) begin
                x = hx.idx;
                y = hy.idx;
            end
        end
        return hop[x][0].vld ? hop[x][0].idx : '0;
    endfunction

    task note_word(logic [lcal_pkg::CMD_W-1:0] cmd, logic [lcal_pkg::NODE_W-1:0] a,
                   logic [lcal_pkg::NODE_W-1:0] b);
        logic [lcal_pkg::DEPTH_W-1:0] d;
        hop_t cur;
        case (cmd)
            lcal_pkg::CMD_ROOT: begin
                depth[a] = '0;
                for (int k = 0; k < LL; k++) hop[a][k] = '0;
                attaches++;
            end
            lcal_pkg::CMD_CHILD: begin
                d = depth[b];
                depth[a] = (d == lcal_pkg::DEPTH_MAX) ? lcal_pkg::DEPTH_MAX : d + 1'b1;
                cur.vld = 1'b1;
                cur.idx = b;
                hop[a][0] = cur;
                // level k is read after level k-1 of this node was written
                for (int k = 1; k < LL; k++) begin
                    cur = cur.vld ? hop[cur.idx][k-1] : '0;
                    hop[a][k] = cur;
                end
                attaches++;
            end
            lcal_pkg::CMD_QUERY: begin
                ancestor_q = {ancestor_q, lowest_common(a, b)};
                queries++;
            end
            default: ;
        endcase
    endtask

    task check_word(logic [lcal_pkg::NODE_W-1:0] got);
        logic [lcal_pkg::NODE_W-1:0] want;
        if (ancestor_q.size() == 0) begin
            report($sformatf("result word %0d with no query pending", got));
        end else begin
            want = ancestor_q.pop_front();
            checked++;
            if (got !== want) begin
                report($sformatf("common_ancestor got %0d expected %0d", got, want));
            end
        end
    endtask
endclass

module lowest_common_ancestor_lifting_tb;
    import lcal_pkg::*;

    localparam int NODES      = MAX_NODES_DEF;
    localparam int LEVELS     = LEVELS_DEF;
    localparam int WORD_COUNT = 1850;
    localparam int MODE_SPAN  = 150;           // counted words per idling phase
    localparam int TAIL       = 4 * LEVELS + 20; // longest query plus margin

    // command 3 has no meaning; the block must drop it silently
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command;
    logic [NODE_W-1:0] s_node;
    logic [NODE_W-1:0] s_other_node;
    logic              m_valid;
    logic              m_ready;
    logic [NODE_W-1:0] m_common_ancestor;

    lca_tracker sb = new();

    idle_mode_t mode           = IDLE_NONE;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         words_sent     = 0;

    lowest_common_ancestor_lifting dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_node            (s_node),
        .s_other_node      (s_other_node),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_common_ancestor (m_common_ancestor)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #(10_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Both handshakes are sampled at the edge, before any of this edge's
    // updates land. The result is checked first so that a query taken on the
    // same edge cannot mask an unexpected word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_word(m_common_ancestor);
            if (s_valid && s_ready) sb.note_word(s_command, s_node, s_other_node);
        end
    end

    // receiver: per-cycle stall chance set by the current idling phase
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic set_mode(idle_mode_t m);
        mode = m;
        send_idle_pct  = (m == IDLE_SEND) ? 57 : (m == IDLE_BOTH) ? 15 : 0;
        recv_stall_pct = (m == IDLE_RECV) ? 57 : (m == IDLE_BOTH) ? 15 : 0;
    endtask

    // One word on the input channel. Idle gaps come first; now and then a
    // long gap so valid also shows up late in a busy stretch of the block.
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] a,
                             logic [NODE_W-1:0] b);
        int gap_pct;
        gap_pct = send_idle_pct;
        if (send_idle_pct != 0 && $urandom_range(0, 19) == 0) gap_pct = 95;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_node       <= a;
        s_other_node <= b;
        do @(posedge aclk); while (!s_ready);
        if (cmd != CMD_UNUSED) begin
            words_sent++;
            if (words_sent % MODE_SPAN == 0) begin
                set_mode(idle_mode_t'((int'(mode) + 1) % 4));
            end
        end
    endtask

    // sender holds off until every pending answer has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int perm [NODES];
        int i, j, t, sel, k;
        logic [NODE_W-1:0] a, b;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_command    <= CMD_ROOT;
        s_node       <= '0;
        s_other_node <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed words: small hand-built forest --------------------
        send_word(CMD_ROOT,   10'd0,    10'd1023); // other_node ignored on root
        send_word(CMD_UNUSED, 10'd1023, 10'd1023); // dropped, no answer
        send_word(CMD_QUERY,  10'd0,    10'd0);    // node with itself
        send_word(CMD_ROOT,   10'd1023, 10'd0);
        send_word(CMD_QUERY,  10'd0,    10'd1023); // two roots: no common ancestor
        send_word(CMD_CHILD,  10'd1,    10'd0);
        send_word(CMD_CHILD,  10'd2,    10'd1);
        send_word(CMD_CHILD,  10'd3,    10'd2);
        send_word(CMD_CHILD,  10'd4,    10'd1);
        send_word(CMD_CHILD,  10'd512,  10'd1023);
        send_word(CMD_CHILD,  10'd513,  10'd512);
        send_word(CMD_QUERY,  10'd3,    10'd4);    // siblings' branches meet at 1
        send_word(CMD_QUERY,  10'd4,    10'd3);    // deeper node second
        send_word(CMD_QUERY,  10'd3,    10'd0);    // one is the other's ancestor
        send_word(CMD_QUERY,  10'd2,    10'd3);
        send_word(CMD_QUERY,  10'd3,    10'd513);  // different trees
        send_word(CMD_QUERY,  10'd513,  10'd1023);
        // move 2 into the other tree; 3 keeps its old ancestors
        send_word(CMD_CHILD,  10'd2,    10'd513);
        send_word(CMD_QUERY,  10'd2,    10'd512);
        send_word(CMD_QUERY,  10'd3,    10'd4);
        send_word(CMD_CHILD,  10'd4,    10'd4);    // node made its own parent
        send_word(CMD_QUERY,  10'd4,    10'd1);
        send_word(CMD_ROOT,   10'd3,    10'd1023); // re-root an attached node
        send_word(CMD_QUERY,  10'd3,    10'd3);
        send_word(CMD_UNUSED, 10'd0,    10'd0);

        wait_drained();

        // ---- one chain through every node, depth up to 1023 --------------
        for (i = 0; i < NODES; i++) perm[i] = i;
        for (i = NODES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        send_word(CMD_ROOT, NODE_W'(perm[0]), NODE_W'($urandom));
        for (i = 1; i < NODES; i++) begin
            send_word(CMD_CHILD, NODE_W'(perm[i]), NODE_W'(perm[i-1]));
            if ($urandom_range(0, 99) < 15) begin
                send_word(CMD_QUERY, NODE_W'(perm[$urandom_range(0, i)]),
                          NODE_W'(perm[$urandom_range(0, i)]));
            end
        end
        // hang the root under the deepest node: depth saturates, loop forms
        send_word(CMD_QUERY, NODE_W'(perm[0]), NODE_W'(perm[NODES-1]));
        send_word(CMD_CHILD, NODE_W'(perm[0]), NODE_W'(perm[NODES-1]));
        send_word(CMD_QUERY, NODE_W'(perm[0]), NODE_W'(perm[NODES-1]));
        send_word(CMD_QUERY, NODE_W'(perm[NODES/2]), NODE_W'(perm[0]));
        send_word(CMD_CHILD, NODE_W'(perm[7]), NODE_W'(perm[0]));
        send_word(CMD_QUERY, NODE_W'(perm[7]), NODE_W'(perm[NODES-2]));

        // ---- random mix; every node is attached from here on -------------
        while (words_sent < WORD_COUNT) begin
            sel = $urandom_range(0, 99);
            a = NODE_W'($urandom);
            b = NODE_W'($urandom);
            if (sel < 52) begin
                // bias some queries toward related pairs
                if ($urandom_range(0, 3) == 0) begin
                    k = $urandom_range(0, LEVELS - 1);
                    if (sb.hop[a][k].vld) b = sb.hop[a][k].idx;
                end else if ($urandom_range(0, 15) == 0) begin
                    b = a;
                end
                send_word(CMD_QUERY, a, b);
            end else if (sel < 84) begin
                if ($urandom_range(0, 31) == 0) b = a;
                send_word(CMD_CHILD, a, b);
            end else if (sel < 93) begin
                send_word(CMD_ROOT, a, b);
            end else begin
                send_word(CMD_UNUSED, a, b);
            end
        end

        wait_drained();
        repeat (TAIL) @(posedge aclk);

        $display("Covered %0d attach words and %0d queries (%0d answers checked),",
                 sb.attaches, sb.queries, sb.checked);
        $display("a full-depth chain with saturation, four idling phases, %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
